### hdl/assert_macros.svh
// assertion helpers included by rolling_average_filter.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every rising clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

### hdl/rafilt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rafilt_pkg;

    // field widths of the sample and result beats
    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned CNT_W    = 7;

    // largest window the 7-bit register can express
    localparam int unsigned CNT_MAX  = 127;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic        [CNT_W-1:0]    t_count;

endpackage

`default_nettype wire

### hdl/rafilt_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module rafilt_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

### hdl/rolling_average_filter.sv
`timescale 1ns / 1ps
`default_nettype none
// a sample beat is taken only while idle: the filter holds o_stall until
//   the previous result has loaded; the restoring divider takes one
//   quotient bit per cycle over the 16+log2(MAX_WINDOW) bit running sum
// a result waiting in the output register does not block the next sample
// reset (synchronous, active low): window min(MAX_WINDOW, 127), empty history, no ring clear

`include "assert_macros.svh"

module rolling_average_filter #(
    parameter int unsigned MAX_WINDOW = 64
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // sample channel
    input  wire logic                               i_valid,
    output logic                                    o_stall,
    input  wire logic signed [rafilt_pkg::SAMPLE_W-1:0] i_sample,
    // result channel
    output logic                                    o_valid,
    input  wire logic                               i_stall,
    output logic signed [rafilt_pkg::SAMPLE_W-1:0]  o_average,
    output logic        [rafilt_pkg::CNT_W-1:0]     o_samples_used,
    // window size register
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic        [rafilt_pkg::CNT_W-1:0] i_window_size
);

    localparam int unsigned SW     = $clog2(MAX_WINDOW);
    localparam int unsigned SUMW   = rafilt_pkg::SAMPLE_W + SW;
    localparam int unsigned CMPW   = (SW + 1 > rafilt_pkg::CNT_W) ? SW + 1 : rafilt_pkg::CNT_W;
    localparam int unsigned DIV_CW = $clog2(SUMW);
    localparam int unsigned WIN_MAX =
        (MAX_WINDOW < rafilt_pkg::CNT_MAX) ? MAX_WINDOW : rafilt_pkg::CNT_MAX;
    localparam logic [rafilt_pkg::CNT_W-1:0] WIN_MAX_C = rafilt_pkg::CNT_W'(WIN_MAX);
    localparam logic [DIV_CW-1:0]            DIV_LAST  = DIV_CW'(SUMW - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DIV,
        ST_FINISH
    } t_state;

    t_state                       r_state;
    rafilt_pkg::t_count           r_window;
    rafilt_pkg::t_count           r_fill;
    logic [SW-1:0]                r_slot;
    logic signed [SUMW-1:0]       r_sum;
    rafilt_pkg::t_sample          r_sample;
    rafilt_pkg::t_count           r_divisor;
    rafilt_pkg::t_count           r_rem;
    logic [SUMW-1:0]              r_quo;
    logic                         r_neg;
    logic [DIV_CW-1:0]            r_div_cnt;
    logic                         r_out_valid;
    rafilt_pkg::t_sample          r_average;
    rafilt_pkg::t_count           r_samples_used;

    logic signed [SUMW-1:0]       n_sum;
    rafilt_pkg::t_count           n_fill;
    logic [SW-1:0]                n_slot;
    rafilt_pkg::t_count           n_window;
    rafilt_pkg::t_count           n_rem;
    logic [SUMW-1:0]              n_quo;
    rafilt_pkg::t_sample          n_average;

    rafilt_pkg::t_sample          w_old;
    logic [rafilt_pkg::SAMPLE_W-1:0] w_old_raw;
    logic                         w_full;
    logic [CMPW-1:0]              w_slot_inc;
    logic [CMPW-1:0]              w_slot_ext;
    logic [CMPW-1:0]              w_window_ext;
    logic [rafilt_pkg::CNT_W:0]   w_rem_sh;
    logic                         w_ge;
    logic [rafilt_pkg::SAMPLE_W-1:0] w_quo_low;
    logic                         w_accept;
    logic                         w_cfg_wr;
    logic                         w_out_load;

    assign o_stall        = (r_state != ST_IDLE);
    assign o_cfg_ready    = (r_state == ST_IDLE);
    assign o_valid        = r_out_valid;
    assign o_average      = r_average;
    assign o_samples_used = r_samples_used;

    assign w_accept   = i_valid && !o_stall;
    assign w_cfg_wr   = i_cfg_valid && o_cfg_ready;
    assign w_out_load = (r_state == ST_FINISH) && (!r_out_valid || !i_stall);

    // sample ring, read at the current slot every cycle
    rafilt_ram #(
        .WIDTH (rafilt_pkg::SAMPLE_W),
        .DEPTH (MAX_WINDOW)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (r_state == ST_UPDATE),
        .i_wr_addr (r_slot),
        .i_wr_data (r_sample),
        .i_rd_addr (r_slot),
        .o_rd_data (w_old_raw)
    );

    assign w_old = signed'(w_old_raw);

    // window clamp on a register write
    always_comb begin
        n_window = i_window_size;
        if (i_window_size == '0) begin
            n_window = rafilt_pkg::CNT_W'(1);
        end else if (i_window_size > WIN_MAX_C) begin
            n_window = WIN_MAX_C;
        end
    end

    // ring bookkeeping and running sum update
    always_comb begin
        w_full       = (r_fill >= r_window);
        w_slot_ext   = CMPW'(r_slot);
        w_window_ext = CMPW'(r_window);
        w_slot_inc   = w_slot_ext + CMPW'(1);
        n_sum        = r_sum + SUMW'(r_sample);
        n_fill       = r_fill + rafilt_pkg::CNT_W'(1);
        if (w_full) begin
            n_sum  = r_sum - SUMW'(w_old) + SUMW'(r_sample);
            n_fill = r_fill;
        end
        n_slot = (w_slot_inc >= w_window_ext) ? '0 : w_slot_inc[SW-1:0];
    end

    // one restoring division step
    always_comb begin
        w_rem_sh = {r_rem, r_quo[SUMW-1]};
        w_ge     = (w_rem_sh >= {1'b0, r_divisor});
        n_rem    = w_ge ? rafilt_pkg::CNT_W'(w_rem_sh - {1'b0, r_divisor})
                        : w_rem_sh[rafilt_pkg::CNT_W-1:0];
        n_quo    = {r_quo[SUMW-2:0], w_ge};
    end

    // sign restore of the quotient
    always_comb begin
        w_quo_low = r_quo[rafilt_pkg::SAMPLE_W-1:0];
        n_average = r_neg ? signed'(-w_quo_low) : signed'(w_quo_low);
    end

    // sequencer, history state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_window    <= WIN_MAX_C;
            r_fill      <= '0;
            r_slot      <= '0;
            r_sum       <= '0;
            r_div_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // drop the result beat once taken, unless a new one loads now
            if (r_out_valid && !i_stall && !w_out_load) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_cfg_wr) begin
                        r_window <= n_window;
                        r_fill   <= '0;
                        r_slot   <= '0;
                        r_sum    <= '0;
                    end
                    if (w_accept) begin
                        r_sample <= i_sample;
                        r_state  <= ST_UPDATE;
                    end
                end
                ST_UPDATE: begin
                    r_sum     <= n_sum;
                    r_fill    <= n_fill;
                    r_slot    <= n_slot;
                    r_divisor <= n_fill;
                    r_neg     <= n_sum[SUMW-1];
                    r_quo     <= n_sum[SUMW-1] ? SUMW'(-n_sum) : SUMW'(n_sum);
                    r_rem     <= '0;
                    r_div_cnt <= DIV_LAST;
                    r_state   <= ST_DIV;
                end
                ST_DIV: begin
                    r_rem     <= n_rem;
                    r_quo     <= n_quo;
                    r_div_cnt <= r_div_cnt - DIV_CW'(1);
                    if (r_div_cnt == '0) begin
                        r_state <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (w_out_load) begin
                        r_out_valid    <= 1'b1;
                        r_average      <= n_average;
                        r_samples_used <= r_divisor;
                        r_state        <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    `ASSERT_ALWAYS(a_fill_in_window, i_clk, i_rst_n, r_fill <= r_window, "fill count above window")
    `ASSERT_ALWAYS(a_slot_in_window, i_clk, i_rst_n, w_slot_ext < w_window_ext, "write slot outside window")
    `ASSERT_NEVER(a_div_by_zero, i_clk, i_rst_n, (r_state == ST_DIV) && (r_divisor == '0), "divide by zero")
    `ASSERT_ALWAYS(a_rem_below_div, i_clk, i_rst_n, (r_state != ST_DIV) || (r_rem < r_divisor), "remainder not below divisor")

endmodule

`default_nettype wire

### tb/sv/tb_rolling_average_filter.sv
`timescale 1ns / 1ps

module tb_rolling_average_filter;

    typedef rafilt_pkg::t_sample t_sample;
    typedef rafilt_pkg::t_count  t_count;

    localparam int unsigned WINDOW_DEPTH = 64;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned PHASE_ITEMS  = 105;
    localparam int unsigned SETTLE_LIMIT = 40;

    // sample mixes for the random phases
    typedef enum int unsigned {
        MIX_ANY,
        MIX_NEAR_MAX,
        MIX_NEAR_MIN
    } t_sample_mix;

    typedef struct {
        t_sample average;
        t_count  used;
    } t_average_beat;

    // moving average predictor and in-order store of expected averages
    class average_board;
        t_sample       history [WINDOW_DEPTH];
        int unsigned   next_slot;
        int unsigned   fill;
        int unsigned   window;
        longint        sum;
        t_average_beat expected_avgs [$];
        int unsigned   failures;
        int unsigned   samples_seen;
        int unsigned   averages_checked;

        function new();
            window           = WINDOW_DEPTH;
            failures         = 0;
            samples_seen     = 0;
            averages_checked = 0;
            clear_history();
        endfunction

        function void clear_history();
            next_slot = 0;
            fill      = 0;
            sum       = 0;
        endfunction

        // register write: zero means one, anything above the depth saturates
        function void set_window(t_count value);
            int unsigned w;
            w = value;
            if (w == 0) begin
                w = 1;
            end
            if (w > WINDOW_DEPTH) begin
                w = WINDOW_DEPTH;
            end
            window = w;
            clear_history();
        endfunction

        function void note_sample(t_sample smp);
            int unsigned   slot;
            longint        mag;
            longint        quot;
            t_average_beat beat;
            slot = next_slot;
            if (slot >= window) begin
                slot = 0;
            end
            // once full, the oldest sample in this slot drops out of the sum
            if (fill >= window) begin
                sum -= history[slot];
            end else begin
                fill++;
            end
            history[slot] = smp;
            sum += smp;
            next_slot = (slot + 1 >= window) ? 0 : slot + 1;
            // divide the magnitude so the quotient truncates toward zero
            mag  = (sum < 0) ? -sum : sum;
            quot = mag / fill;
            beat.average = t_sample'((sum < 0) ? -quot : quot);
            beat.used    = t_count'(fill);
            expected_avgs.push_back(beat);
            samples_seen++;
        endfunction

        function void check_average(t_sample average, t_count used);
            t_average_beat exp_beat;
            if (expected_avgs.size() == 0) begin
                $display("%0t: average beat with none expected, got average %0d used %0d",
                         $time, average, used);
                failures++;
                return;
            end
            exp_beat = expected_avgs.pop_front();
            averages_checked++;
            if (average !== exp_beat.average) begin
                $display("%0t: average mismatch, expected %0d, got %0d",
                         $time, exp_beat.average, average);
                failures++;
            end
            if (used !== exp_beat.used) begin
                $display("%0t: samples_used mismatch, expected %0d, got %0d",
                         $time, exp_beat.used, used);
                failures++;
            end
        endfunction

        function int unsigned pending();
            return expected_avgs.size();
        endfunction
    endclass

    logic    i_clk         = 1'b0;
    logic    i_rst_n       = 1'b0;
    logic    i_valid       = 1'b0;
    t_sample i_sample      = '0;
    logic    i_stall       = 1'b0;
    logic    i_cfg_valid   = 1'b0;
    t_count  i_window_size = '0;
    logic    o_stall;
    logic    o_valid;
    t_sample o_average;
    t_count  o_samples_used;
    logic    o_cfg_ready;

    average_board board;
    bit           hold_wanted     = 1'b0;
    int unsigned  windows_written = 0;

    rolling_average_filter #(
        .MAX_WINDOW     (WINDOW_DEPTH)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_sample       (i_sample),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_average      (o_average),
        .o_samples_used (o_samples_used),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_window_size  (i_window_size)
    );

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("tb_rolling_average_filter failed");
        $finish;
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            board.check_average(o_average, o_samples_used);
        end
    end

    // result side stall pattern, with one long hold on request
    initial begin : result_sink
        int unsigned stall_pct;
        int unsigned span;
        stall_pct = 0;
        span      = 0;
        forever begin
            @(posedge i_clk);
            if (hold_wanted) begin
                hold_wanted = 1'b0;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            if (span == 0) begin
                case ($urandom_range(4))
                    0, 1:    stall_pct = 0;
                    2:       stall_pct = 25;
                    3:       stall_pct = 60;
                    default: stall_pct = 90;
                endcase
                span = $urandom_range(20, 200);
            end
            span--;
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    function automatic t_sample pick_sample(t_sample_mix mix);
        case (mix)
            MIX_NEAR_MAX: return t_sample'(32767 - int'($urandom_range(15)));
            MIX_NEAR_MIN: return t_sample'(-32768 + int'($urandom_range(15)));
            default: begin
                case ($urandom_range(9))
                    0:       return t_sample'(32767);
                    1:       return t_sample'(-32768);
                    2, 3:    return t_sample'(int'($urandom_range(511)) - 256);
                    default: return t_sample'($urandom);
                endcase
            end
        endcase
    endfunction

    // offer one sample beat and wait for it to be taken
    task automatic send_sample(input t_sample smp);
        i_valid  <= 1'b1;
        i_sample <= smp;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        board.note_sample(smp);
    endtask

    // back-to-back beats, then release the channel
    task automatic send_list(input t_sample list [$]);
        foreach (list[k]) send_sample(list[k]);
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (board.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_window(input t_count value);
        i_cfg_valid   <= 1'b1;
        i_window_size <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        board.set_window(value);
        windows_written++;
    endtask

    // random bursts with random gaps, ending with the channel idle
    task automatic run_phase(input int unsigned count, input t_sample_mix mix);
        int unsigned burst;
        int unsigned gap;
        while (count > 0) begin
            burst = $urandom_range(1, 12);
            if (burst > count) begin
                burst = count;
            end
            repeat (burst) send_sample(pick_sample(mix));
            count -= burst;
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 40);
            if (count == 0 && gap == 0) begin
                gap = 1;
            end
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    initial begin : stimulus
        t_count      win_plan [$];
        t_sample_mix mix;
        board = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset window: extremes and the smallest magnitudes
        send_list('{t_sample'(32767), t_sample'(-32768), t_sample'(-1),
                    t_sample'(0), t_sample'(1)});
        wait_drained();

        // window of two: truncation toward zero both ways, full-scale pairs
        write_window(t_count'(2));
        send_list('{t_sample'(-1), t_sample'(-2), t_sample'(1), t_sample'(2),
                    t_sample'(32767), t_sample'(32767),
                    t_sample'(-32768), t_sample'(-32768)});
        wait_drained();

        // zero is taken as a window of one
        write_window(t_count'(0));
        send_list('{t_sample'(12345), t_sample'(-32768), t_sample'(32767)});
        wait_drained();

        // oversized writes saturate at the built depth
        write_window(t_count'(127));
        send_list('{t_sample'(21845), t_sample'(-21846)});
        wait_drained();
        write_window(t_count'(65));
        send_list('{t_sample'(100)});
        wait_drained();

        // random phases over a spread of window settings
        win_plan = '{t_count'(1), t_count'(64), t_count'(3), t_count'(127),
                     t_count'(0), t_count'($urandom_range(1, 64)), t_count'(63),
                     t_count'(2), t_count'($urandom_range(1, 64)), t_count'(64)};
        foreach (win_plan[ph]) begin
            write_window(win_plan[ph]);
            mix = (ph == 3) ? MIX_NEAR_MAX : (ph == 9) ? MIX_NEAR_MIN : MIX_ANY;
            if (ph == 4) begin
                hold_wanted = 1'b1;
            end
            run_phase(PHASE_ITEMS, mix);
            wait_drained();
        end

        // let any stray beat show up before the verdict
        repeat (SETTLE_LIMIT) @(posedge i_clk);
        if (board.pending() != 0) begin
            $display("%0t: %0d averages never arrived", $time, board.pending());
            board.failures++;
        end

        $display("run covered %0d sample beats and %0d average beats over %0d window writes",
                 board.samples_seen, board.averages_checked, windows_written);
        $display("windows from 1 to 64 incl. zero and oversized writes, one %0d-cycle hold",
                 HOLD_CYCLES);
        if (board.failures == 0) begin
            $display("tb_rolling_average_filter passed");
        end else begin
            $display("tb_rolling_average_filter failed");
        end
        $finish;
    end

endmodule
